// ===== src/mcfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared types for the motor command frame encoder: command codes,
// configuration register indexes, the configuration bundle and the frame
// descriptor that travels from the front end to the byte sequencer.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  // Command codes carried in the action field
  typedef enum logic [2:0] {
    ACT_SPEED    = 3'd0,
    ACT_CURRENT  = 3'd1,
    ACT_POSITION = 3'd2,
    ACT_BRAKE    = 3'd3,
    ACT_QUERY    = 3'd4,
    ACT_MODE     = 3'd5
  } action_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAX_RPM        = 3'd0,
    CFG_MIN_RPM        = 3'd1,
    CFG_CONTROL_OPCODE = 3'd2,
    CFG_QUERY_OPCODE   = 3'd3,
    CFG_MODE_OPCODE    = 3'd4
  } cfg_index_e;

  // Configuration register contents
  typedef struct packed {
    logic [14:0] max_rpm;
    logic [15:0] min_rpm;
    logic [7:0]  control_opcode;
    logic [7:0]  query_opcode;
    logic [7:0]  mode_opcode;
  } cfg_regs_t;

  // One classified command, ready to be serialized
  typedef struct packed {
    logic [7:0]  dest_addr;
    logic [7:0]  opcode;
    logic [15:0] value;
    logic        brake;
    logic        mode_set;
    logic [7:0]  mode_value;
  } frame_desc_t;

endpackage

// ===== src/mcfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_front
// Accepts command items, drops unused action codes, clamps speed commands
// and picks the opcode, then pushes a frame descriptor into the queue.
// ----------------------------------------------------------------------------
module mcfe_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           action_i,
  input  logic [7:0]           dest_addr_i,
  input  logic [15:0]          value_i,
  input  logic [7:0]           mode_value_i,
  input  mcfe_pkg::cfg_regs_t  cfg_i,
  output logic                 push_o,
  output mcfe_pkg::frame_desc_t push_data_o,
  input  logic                 full_i
);
  import mcfe_pkg::*;

  logic signed [15:0] spd_s;
  logic signed [15:0] hi_s;
  logic signed [15:0] lo_s;
  logic [15:0]        spd_clamped;
  logic               known;

  // Clamp speed: upper bound first, then lower bound
  always_comb begin
    spd_s = signed'(value_i);
    hi_s  = signed'({1'b0, cfg_i.max_rpm});
    lo_s  = signed'(cfg_i.min_rpm);
    if (spd_s > hi_s) begin
      spd_clamped = unsigned'(hi_s);
    end else if (spd_s < lo_s) begin
      spd_clamped = unsigned'(lo_s);
    end else begin
      spd_clamped = value_i;
    end
  end

  // Classify the command and build the descriptor
  always_comb begin
    push_data_o            = '0;
    push_data_o.dest_addr  = dest_addr_i;
    push_data_o.mode_value = mode_value_i;
    known                  = 1'b1;
    unique case (action_e'(action_i))
      ACT_SPEED: begin
        push_data_o.opcode = cfg_i.control_opcode;
        push_data_o.value  = spd_clamped;
      end
      ACT_CURRENT, ACT_POSITION: begin
        push_data_o.opcode = cfg_i.control_opcode;
        push_data_o.value  = value_i;
      end
      ACT_BRAKE: begin
        push_data_o.opcode = cfg_i.control_opcode;
        push_data_o.brake  = 1'b1;
      end
      ACT_QUERY: begin
        push_data_o.opcode = cfg_i.query_opcode;
      end
      ACT_MODE: begin
        push_data_o.opcode   = cfg_i.mode_opcode;
        push_data_o.mode_set = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Stall only on a full queue; unused codes are taken and dropped
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && known;

endmodule

// ===== src/mcfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_queue
// Short register queue of frame descriptors between the front end and the
// byte sequencer.
// ----------------------------------------------------------------------------
module mcfe_queue #(
  parameter int Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mcfe_pkg::frame_desc_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output mcfe_pkg::frame_desc_t pop_data_o
);
  import mcfe_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  frame_desc_t     mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Advance pointers and the fill count
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store pushed descriptors
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

endmodule

// ===== src/mcfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_back
// Byte sequencer: takes one descriptor, emits the ten frame bytes one per
// cycle unless stalled, through an output register, folding each byte into a
// running CRC-8/MAXIM that becomes the final byte except on mode frames.
// ----------------------------------------------------------------------------
module mcfe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  desc_valid_i,
  input  mcfe_pkg::frame_desc_t desc_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            tx_byte_o,
  output logic [3:0]            byte_index_o,
  output logic                  last_o
);
  import mcfe_pkg::*;

  localparam logic [3:0] IdxId     = 4'd0;
  localparam logic [3:0] IdxOpcode = 4'd1;
  localparam logic [3:0] IdxValHi  = 4'd2;
  localparam logic [3:0] IdxValLo  = 4'd3;
  localparam logic [3:0] IdxBrake  = 4'd7;
  localparam logic [3:0] IdxLast   = 4'd9;
  localparam logic [7:0] CrcPoly   = 8'h8C;
  localparam logic [7:0] BrakeFlag = 8'hFF;

  // One byte of reflected CRC-8, bit at a time
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic        busy_q, busy_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;
  frame_desc_t desc_q, desc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [3:0]  out_index_q, out_index_d;
  logic        out_last_q, out_last_d;
  logic        adv;
  logic        emit;
  logic        fin;
  logic [7:0]  cur_byte;

  // Select the frame byte at the current position
  always_comb begin
    unique case (idx_q)
      IdxId:     cur_byte = desc_q.dest_addr;
      IdxOpcode: cur_byte = desc_q.opcode;
      IdxValHi:  cur_byte = desc_q.value[15:8];
      IdxValLo:  cur_byte = desc_q.value[7:0];
      IdxBrake:  cur_byte = desc_q.brake ? BrakeFlag : 8'h00;
      IdxLast:   cur_byte = desc_q.mode_set ? desc_q.mode_value : crc_q;
      default:   cur_byte = 8'h00;
    endcase
  end

  // Sequence bytes, load the next descriptor as the last byte leaves
  always_comb begin
    adv   = !out_valid_q || !out_stall_i;
    emit  = adv && busy_q;
    fin   = emit && (idx_q == IdxLast);
    pop_o = desc_valid_i && (!busy_q || fin);

    busy_d      = busy_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    desc_d      = desc_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_index_d = out_index_q;
    out_last_d  = out_last_q;

    if (emit) begin
      idx_d       = 4'(idx_q + 4'd1);
      crc_d       = crc8_step(crc_q, cur_byte);
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_index_d = idx_q;
      out_last_d  = (idx_q == IdxLast);
    end else if (adv) begin
      out_valid_d = 1'b0;
    end

    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
      crc_d  = '0;
      desc_d = desc_i;
    end else if (fin) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload without reset
  always_ff @(posedge clk_i) begin
    crc_q       <= crc_d;
    desc_q      <= desc_d;
    out_byte_q  <= out_byte_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = out_byte_q;
  assign byte_index_o = out_index_q;
  assign last_o       = out_last_q;

  a_bytes_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_last_q) |=>
      (out_valid_q && (out_index_q == 4'($past(out_index_q) + 4'd1))))
    else $error("frame bytes not back to back");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_index_q == IdxLast))
    else $error("last flag away from final byte");

endmodule

// ===== src/motor_command_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_frame_encoder_core
// Turns motor command items into 10-byte bus frames ending in CRC-8/MAXIM, or in the mode byte for mode frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command item: action,
//   target address, 16-bit value and mode byte. Action codes 6 and 7 are
//   taken and dropped without output.
//   Output channel (out_valid_o / out_stall_i) delivers the frame bytes 0..9
//   in order with byte_index_o, and last_o high on byte 9.
//   Configuration port (cfg_valid_i / cfg_ready_o) is always ready; write it
//   only while no frame is pending. Indexes beyond the register list are
//   ignored.
//   The first byte of a frame passes through the queue, the descriptor
//   register and the output register. Frames go out one at a time through
//   the single byte lane of the output sequencer.
//   A queue of QueueDepth descriptors sits between the front end and the
//   sequencer, so new items are taken while a frame is still going out;
//   when the queue fills, in_stall_o rises.
//   A stall on the output holds the current byte and freezes the sequencer.
//   Reset empties the queue, drops any partial frame and restores the
//   configuration registers to their defaults.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  dest_addr_i,
  input  logic [15:0] value_i,
  input  logic [7:0]  mode_value_i,
  // Frame byte output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic [3:0]  byte_index_o,
  output logic        last_o,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mcfe_pkg::*;

  cfg_regs_t   cfg_q;
  logic        push;
  frame_desc_t push_data;
  logic        full;
  logic        pop;
  logic        q_valid;
  frame_desc_t q_data;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_rpm        <= 15'd200;
      cfg_q.min_rpm        <= 16'hFF38;
      cfg_q.control_opcode <= 8'd100;
      cfg_q.query_opcode   <= 8'd116;
      cfg_q.mode_opcode    <= 8'd160;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_MAX_RPM:        cfg_q.max_rpm        <= cfg_data_i[14:0];
        CFG_MIN_RPM:        cfg_q.min_rpm        <= cfg_data_i;
        CFG_CONTROL_OPCODE: cfg_q.control_opcode <= cfg_data_i[7:0];
        CFG_QUERY_OPCODE:   cfg_q.query_opcode   <= cfg_data_i[7:0];
        CFG_MODE_OPCODE:    cfg_q.mode_opcode    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  mcfe_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .dest_addr_i  (dest_addr_i),
    .value_i      (value_i),
    .mode_value_i (mode_value_i),
    .cfg_i        (cfg_q),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  mcfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  mcfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (q_valid),
    .desc_i       (q_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .byte_index_o (byte_index_o),
    .last_o       (last_o)
  );

endmodule

// ===== sim/motor_command_frame_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_frame_encoder_core_tb
// Self-checking bench for the motor command frame encoder. A driver plays
// queued command items into the block, a monitor builds the expected
// 10-byte frame for every accepted item and checks each output byte in
// order. The run walks several register settings, including the clamp
// extremes and a minimum above the maximum, under varying back-pressure.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder_core_tb;
  import mcfe_pkg::*;

  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] BRAKE_FLAG  = 8'hFF;
  localparam int         FRAME_BYTES = 10;
  localparam int         SETTLE      = 8;
  localparam int         LONG_HOLD   = 60;
  localparam int         STUCK_LIMIT = 1000;
  // Action codes with no frame, and register indexes with no register
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam logic [2:0] CFG_SPARE_5 = 3'd5;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  dest_addr;
    logic [15:0] value;
    logic [7:0]  mode_value;
  } motor_cmd_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic [3:0] byte_index;
    logic       last;
  } frame_byte_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i     = '0;
  logic [7:0]  dest_addr_i  = '0;
  logic [15:0] value_i      = '0;
  logic [7:0]  mode_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [7:0]  tx_byte_o;
  logic [3:0]  byte_index_o;
  logic        last_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i  = '0;
  logic [15:0] cfg_data_i   = '0;

  // Shadow copy of the configuration registers
  logic [14:0]        max_rpm_q  = 15'd200;
  logic signed [15:0] min_rpm_q  = -16'sd200;
  logic [7:0]         ctl_op_q   = 8'd100;
  logic [7:0]         query_op_q = 8'd116;
  logic [7:0]         mode_op_q  = 8'd160;

  motor_cmd_t  cmd_q[$];
  frame_byte_t frame_q[$];
  logic        cmd_live      = 1'b0;
  logic        cmd_taken     = 1'b0;
  int          items_taken   = 0;
  int          fail_count    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        long_hold_req = 1'b0;
  int          hold_left     = 0;
  int          stuck_cycles  = 0;

  motor_command_frame_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .dest_addr_i (dest_addr_i),
    .value_i     (value_i),
    .mode_value_i(mode_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .byte_index_o(byte_index_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Build the ten bytes of the frame for one command and queue them
  function automatic void encode_frame(motor_cmd_t c);
    logic [7:0]  fr [FRAME_BYTES];
    logic [15:0] word;
    logic [7:0]  crc;
    int          spd;
    int          hi;
    int          lo;
    if (c.action > ACT_MODE) return;
    foreach (fr[k]) fr[k] = 8'h00;
    word  = '0;
    fr[0] = c.dest_addr;
    case (action_e'(c.action))
      ACT_SPEED: begin
        // clamp against the maximum first, then the minimum
        spd = $signed(c.value);
        hi  = int'(max_rpm_q);
        lo  = min_rpm_q;
        if (spd > hi) spd = hi;
        else if (spd < lo) spd = lo;
        fr[1] = ctl_op_q;
        word  = 16'(spd);
      end
      ACT_CURRENT, ACT_POSITION: begin
        fr[1] = ctl_op_q;
        word  = c.value;
      end
      ACT_BRAKE: begin
        fr[1] = ctl_op_q;
        fr[7] = BRAKE_FLAG;
      end
      ACT_QUERY: fr[1] = query_op_q;
      default:   fr[1] = mode_op_q;
    endcase
    fr[2] = word[15:8];
    fr[3] = word[7:0];
    // reflected CRC-8 over bytes 0..8, zero seed
    crc = 8'h00;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      crc = crc ^ fr[i];
      for (int b = 0; b < 8; b++) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    fr[9] = (c.action == ACT_MODE) ? c.mode_value : crc;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      frame_q.push_back('{fr[k], 4'(k), k == FRAME_BYTES - 1});
    end
  endfunction

  function automatic void queue_cmd(logic [2:0] act, logic [7:0] id, logic [15:0] val,
                                    logic [7:0] mode);
    motor_cmd_t c;
    c = '{act, id, val, mode};
    cmd_q.push_back(c);
  endfunction

  // Queue random commands; spare actions are sprinkled in but not counted
  task automatic queue_random_cmds(int count);
    motor_cmd_t c;
    int         made;
    int         off;
    made = 0;
    while (made < count) begin
      c.dest_addr  = 8'($urandom_range(255, 0));
      c.mode_value = 8'($urandom_range(255, 0));
      c.value      = 16'($urandom_range(65535, 0));
      if ($urandom_range(9, 0) == 0) begin
        c.action = $urandom_range(1, 0) ? ACT_SPARE_6 : ACT_SPARE_7;
      end else begin
        c.action = 3'($urandom_range(ACT_MODE, ACT_SPEED));
        made++;
      end
      // push some speeds right onto the clamp edges
      if (c.action == ACT_SPEED && $urandom_range(2, 0) == 0) begin
        off = $urandom_range(4, 0);
        off = off - 2;
        if ($urandom_range(1, 0)) c.value = 16'(int'(max_rpm_q) + off);
        else c.value = 16'(int'(min_rpm_q) + off);
      end
      cmd_q.push_back(c);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_MAX_RPM:        max_rpm_q  = data[14:0];
      CFG_MIN_RPM:        min_rpm_q  = data;
      CFG_CONTROL_OPCODE: ctl_op_q   = data[7:0];
      CFG_QUERY_OPCODE:   query_op_q = data[7:0];
      CFG_MODE_OPCODE:    mode_op_q  = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every queued item is taken and every frame byte has come out
  task automatic wait_drained();
    while (cmd_q.size() != 0 || cmd_live || frame_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Driver: present the next item once the previous one is taken
  always @(negedge clk_i) begin
    motor_cmd_t nxt;
    logic       nxt_valid;
    nxt_valid = cmd_live;
    if (cmd_taken) begin
      nxt_valid = 1'b0;
      cmd_taken = 1'b0;
    end
    if (rst_ni && !nxt_valid && cmd_q.size() != 0 &&
        $urandom_range(99, 0) >= send_idle_pct) begin
      nxt = cmd_q.pop_front();
      action_i     <= nxt.action;
      dest_addr_i  <= nxt.dest_addr;
      value_i      <= nxt.value;
      mode_value_i <= nxt.mode_value;
      nxt_valid    = 1'b1;
    end
    cmd_live = nxt_valid;
    in_valid_i <= nxt_valid;
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    logic nxt_stall;
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      nxt_stall = 1'b1;
      hold_left--;
    end else begin
      nxt_stall = $urandom_range(99, 0) < recv_idle_pct;
    end
    out_stall_i <= nxt_stall;
  end

  // Monitor: predict on accepted items, check accepted frame bytes
  always @(posedge clk_i) begin
    motor_cmd_t  seen;
    frame_byte_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen = '{action_i, dest_addr_i, value_i, mode_value_i};
      encode_frame(seen);
      cmd_taken = 1'b1;
      items_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        $error("unexpected frame byte: tx_byte %0h byte_index %0d", tx_byte_o, byte_index_o);
        fail_count++;
      end else begin
        want = frame_q.pop_front();
        if (tx_byte_o !== want.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", want.tx_byte, tx_byte_o);
          fail_count++;
        end
        if (byte_index_o !== want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want.byte_index, byte_index_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no handshake completes for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    int mark;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, sender mostly busy, receiver mostly stalled
    send_idle_pct = 12;
    recv_idle_pct = 67;
    queue_cmd(ACT_SPEED,    8'h00, 16'h0000, 8'h00);
    queue_cmd(ACT_SPEED,    8'hFF, 16'd200,  8'hFF);
    queue_cmd(ACT_SPEED,    8'h01, 16'd201,  8'h00);
    queue_cmd(ACT_SPEED,    8'h02, 16'h7FFF, 8'h00);
    queue_cmd(ACT_SPEED,    8'h03, 16'h8000, 8'h00);
    queue_cmd(ACT_SPEED,    8'h04, 16'hFF38, 8'h00);
    queue_cmd(ACT_SPEED,    8'h05, 16'hFF37, 8'h00);
    queue_cmd(ACT_SPEED,    8'h06, 16'hFFFF, 8'h00);
    queue_cmd(ACT_CURRENT,  8'h10, 16'hFFFF, 8'h00);
    queue_cmd(ACT_CURRENT,  8'h11, 16'h8000, 8'hFF);
    queue_cmd(ACT_POSITION, 8'h12, 16'h7FFF, 8'h00);
    queue_cmd(ACT_POSITION, 8'h13, 16'h1234, 8'h00);
    // value is ignored on these, and the mode byte on all but the mode commands
    queue_cmd(ACT_BRAKE,    8'h5A, 16'hABCD, 8'hFF);
    queue_cmd(ACT_QUERY,    8'hA5, 16'hFFFF, 8'hFF);
    queue_cmd(ACT_MODE,     8'h7E, 16'h5555, 8'hFF);
    queue_cmd(ACT_MODE,     8'h81, 16'h0000, 8'h00);
    // spare codes must produce nothing
    queue_cmd(ACT_SPARE_6,  8'hFF, 16'hFFFF, 8'hFF);
    queue_cmd(ACT_SPARE_7,  8'h00, 16'h0000, 8'h00);
    queue_cmd(ACT_BRAKE,    8'hFF, 16'h0000, 8'h00);
    queue_cmd(ACT_QUERY,    8'h00, 16'h0000, 8'h00);
    wait_drained();
    queue_random_cmds(12);
    wait_drained();
    queue_random_cmds(8);
    wait_drained();

    // Minimum above maximum, odd opcodes, and a write to a missing register
    write_reg(CFG_MAX_RPM, 16'd100);
    write_reg(CFG_MIN_RPM, 16'd500);
    write_reg(CFG_CONTROL_OPCODE, 16'h0000);
    write_reg(CFG_QUERY_OPCODE, 16'h00FF);
    write_reg(CFG_MODE_OPCODE, 16'h0000);
    write_reg(CFG_SPARE_5, 16'hFFFF);
    send_idle_pct = 67;
    recv_idle_pct = 12;
    queue_cmd(ACT_SPEED, 8'h20, 16'd600,  8'h00);
    queue_cmd(ACT_SPEED, 8'h21, 16'd100,  8'h00);
    queue_cmd(ACT_SPEED, 8'h22, 16'd50,   8'h00);
    queue_cmd(ACT_SPEED, 8'h23, 16'hFFFB, 8'h00);
    queue_random_cmds(28);
    wait_drained();

    // Full speed range, opcodes flipped, no idling, one long receiver hold
    write_reg(CFG_MAX_RPM, 16'hFFFF);
    write_reg(CFG_MIN_RPM, 16'h8000);
    write_reg(CFG_CONTROL_OPCODE, 16'h00FF);
    write_reg(CFG_QUERY_OPCODE, 16'h0000);
    write_reg(CFG_MODE_OPCODE, 16'h00FF);
    write_reg(CFG_SPARE_7, 16'h0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_cmds(30);
    mark = items_taken;
    while (items_taken < mark + 5) @(negedge clk_i);
    long_hold_req = 1'b1;
    wait_drained();

    // Both clamps at zero
    write_reg(CFG_MAX_RPM, 16'h0000);
    write_reg(CFG_MIN_RPM, 16'h0000);
    write_reg(CFG_CONTROL_OPCODE, 16'h0064);
    queue_random_cmds(8);
    wait_drained();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
